// ===== src/successor_mru_draft_table_top_assert.svh =====
// Assertion macros for the successor table top level.
// Each macro expects clk and rst to be visible where it is used.
`ifndef SUCCESSOR_MRU_DRAFT_TABLE_TOP_ASSERT_SVH
`define SUCCESSOR_MRU_DRAFT_TABLE_TOP_ASSERT_SVH

// Same-cycle implication
`define SMDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication
`define SMDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/smdt_pkg.sv =====
// ----------------------------------------------------------------------------
// smdt_pkg
// Shared types, constants and helpers for the successor table.
// ----------------------------------------------------------------------------
package smdt_pkg;

  localparam int TOK_W      = 17;
  localparam int DEF_VOCAB  = 65536;
  localparam int DEF_SLOTS  = 4;
  localparam int MAX_DEPTH  = 8;
  localparam int TOPK_MAX   = 4;
  localparam int DEPTH_CAP  = 8;
  localparam int WIDTH_CAP  = 4;
  localparam int COUNT_CAP  = 4;

  localparam logic signed [TOK_W-1:0] TOK_EMPTY  = -17'sd1;
  localparam logic [7:0]              STREAK_MAX = 8'd255;
  localparam logic [7:0]              THR_RESET  = 8'd1;

  typedef enum logic [2:0] {
    REQ_PAIR   = 3'd0,
    REQ_TOPK   = 3'd1,
    REQ_LINEAR = 3'd2,
    REQ_CAND   = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_OBS,
    ST_TOPK_LOAD,
    ST_TOPK_STEP,
    ST_TOPK_WRITE,
    ST_READ,
    ST_LIN_EVAL,
    ST_LIN_ISSUE,
    ST_CAND_LOAD,
    ST_CAND_FIRST,
    ST_CAND_NEXT,
    ST_CAND_ISSUE,
    ST_CAND_EVAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic latch_req;
    logic rd_from_token;
    logic obs_write;
    logic topk_load;
    logic topk_step;
    logic topk_write;
    logic read_emit;
    logic lin_step;
    logic cand_load;
    logic cand_first;
    logic cand_step;
    logic cand_next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       tok_ok;
    logic       id0_ok;
    logic       cnt_zero;
    logic       depth_zero;
    logic       slot_ok;
    logic       lin_stop;
    logic       chain_last;
    logic       cand_more;
    logic       depth_one;
    logic       cand_stop;
    logic       topk_done;
    logic       clear_done;
  } sts_t;

  function automatic logic tok_valid(logic signed [TOK_W-1:0] t, int unsigned vocab);
    return !t[TOK_W-1] && (32'(t[15:0]) < vocab);
  endfunction

endpackage

// ===== src/successor_mru_draft_table_top.sv =====
// ----------------------------------------------------------------------------
// successor_mru_draft_table_top: pair, read, top-k, linear-draft and
// candidate-draft requests. A linear draft walk ends on a low streak or an
// empty slot 0; a candidate chain can be cut short by an empty slot 0.
// Results cannot stall; busy is high for the whole request. After reset the
// table clears every row, one row per cycle, with busy high.
// ----------------------------------------------------------------------------
`include "successor_mru_draft_table_top_assert.svh"

module successor_mru_draft_table_top #(
  parameter int VOCAB = smdt_pkg::DEF_VOCAB,
  parameter int SLOTS = smdt_pkg::DEF_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         req_type,
  input  logic signed [16:0] token,
  input  logic signed [16:0] id_first,
  input  logic signed [16:0] id_second,
  input  logic signed [16:0] id_third,
  input  logic signed [16:0] id_fourth,
  input  logic [2:0]         id_count,
  input  logic [3:0]         draft_length,
  input  logic [2:0]         draft_width,
  input  logic signed [3:0]  slot_index,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output logic               result_valid,
  output logic signed [16:0] token_out,
  output logic               has_token,
  output logic [1:0]         candidate_index,
  output logic [2:0]         chain_position,
  output logic               end_of_candidate,
  output logic               was_seen,
  output logic               last
);
  import smdt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Threshold register takes a transaction in any cycle
  assign cfg_ready = 1'b1;

  smdt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  smdt_dp #(.VOCAB(VOCAB), .SLOTS(SLOTS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (req_type),
    .token            (token),
    .id_first         (id_first),
    .id_second        (id_second),
    .id_third         (id_third),
    .id_fourth        (id_fourth),
    .id_count         (id_count),
    .draft_length     (draft_length),
    .draft_width      (draft_width),
    .slot_index       (slot_index),
    .cfg_valid        (cfg_valid),
    .cfg_data         (cfg_data),
    .result_valid     (result_valid),
    .token_out        (token_out),
    .has_token        (has_token),
    .candidate_index  (candidate_index),
    .chain_position   (chain_position),
    .end_of_candidate (end_of_candidate),
    .was_seen         (was_seen),
    .last             (last)
  );

  `SMDT_ASSERT_NXT(a_busy_after_start, start && !busy, busy)
  `SMDT_ASSERT_IMP(a_last_frees_block, result_valid && last, !busy)
  `SMDT_ASSERT_IMP(a_mid_result_busy, result_valid && !last, busy)
  `SMDT_ASSERT_IMP(a_token_nonneg, result_valid && has_token, !token_out[16])

endmodule

// ===== src/smdt_ram.sv =====
// ----------------------------------------------------------------------------
// smdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/smdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// smdt_ctrl
// Request sequencer: clearing pass, observe, top-k, draft and read flows.
// ----------------------------------------------------------------------------
module smdt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  smdt_pkg::sts_t sts,
  output smdt_pkg::cmd_t cmd,
  output logic           busy
);
  import smdt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:      if (sts.clear_done) state_next = ST_IDLE;
      ST_IDLE:       if (start) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts.req)
          REQ_PAIR:   state_next = (sts.tok_ok && sts.id0_ok) ? ST_OBS : ST_FINISH;
          REQ_TOPK:   state_next = (sts.tok_ok && !sts.cnt_zero) ? ST_TOPK_LOAD : ST_FINISH;
          REQ_LINEAR: state_next = (sts.tok_ok && !sts.depth_zero) ? ST_LIN_EVAL : ST_FINISH;
          REQ_CAND:   state_next = (sts.tok_ok && !sts.depth_zero) ? ST_CAND_LOAD : ST_FINISH;
          REQ_READ:   state_next = (sts.tok_ok && sts.slot_ok) ? ST_READ : ST_FINISH;
          default:    state_next = ST_FINISH;
        endcase
      end
      ST_OBS:        state_next = ST_IDLE;
      ST_TOPK_LOAD:  state_next = ST_TOPK_STEP;
      ST_TOPK_STEP:  if (sts.topk_done) state_next = ST_TOPK_WRITE;
      ST_TOPK_WRITE: state_next = ST_IDLE;
      ST_READ:       state_next = ST_IDLE;
      ST_LIN_EVAL:   state_next = (sts.lin_stop || sts.chain_last) ? ST_FINISH : ST_LIN_ISSUE;
      ST_LIN_ISSUE:  state_next = ST_LIN_EVAL;
      ST_CAND_LOAD:  state_next = ST_CAND_FIRST;
      ST_CAND_FIRST: begin
        if (!sts.cand_more) begin
          state_next = ST_FINISH;
        end else if (sts.depth_one) begin
          state_next = ST_CAND_NEXT;
        end else begin
          state_next = ST_CAND_ISSUE;
        end
      end
      ST_CAND_NEXT:  state_next = ST_CAND_FIRST;
      ST_CAND_ISSUE: state_next = ST_CAND_EVAL;
      ST_CAND_EVAL:  state_next = (sts.cand_stop || sts.chain_last) ? ST_CAND_NEXT : ST_CAND_ISSUE;
      ST_FINISH:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_CLEAR:      cmd.clear_wr = 1'b1;
      ST_IDLE:       cmd.latch_req = start;
      ST_DISPATCH:   cmd.rd_from_token = 1'b1;
      ST_OBS:        cmd.obs_write = 1'b1;
      ST_TOPK_LOAD:  cmd.topk_load = 1'b1;
      ST_TOPK_STEP:  cmd.topk_step = 1'b1;
      ST_TOPK_WRITE: cmd.topk_write = 1'b1;
      ST_READ:       cmd.read_emit = 1'b1;
      ST_LIN_EVAL:   cmd.lin_step = !sts.lin_stop;
      ST_LIN_ISSUE:  cmd = '0;
      ST_CAND_LOAD:  cmd.cand_load = 1'b1;
      ST_CAND_FIRST: cmd.cand_first = sts.cand_more;
      ST_CAND_NEXT:  cmd.cand_next = 1'b1;
      ST_CAND_ISSUE: cmd = '0;
      ST_CAND_EVAL:  cmd.cand_step = !sts.cand_stop;
      ST_FINISH:     cmd.finish = 1'b1;
    endcase
  end

endmodule

// ===== src/smdt_dp.sv =====
// ----------------------------------------------------------------------------
// smdt_dp
// Datapath: row and streak memories, request registers, promote logic,
// chain counters and the one-deep result holding stage.
// ----------------------------------------------------------------------------
module smdt_dp #(
  parameter int VOCAB = smdt_pkg::DEF_VOCAB,
  parameter int SLOTS = smdt_pkg::DEF_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  smdt_pkg::cmd_t     cmd,
  output smdt_pkg::sts_t     sts,
  input  logic [2:0]         req_type,
  input  logic signed [16:0] token,
  input  logic signed [16:0] id_first,
  input  logic signed [16:0] id_second,
  input  logic signed [16:0] id_third,
  input  logic signed [16:0] id_fourth,
  input  logic [2:0]         id_count,
  input  logic [3:0]         draft_length,
  input  logic [2:0]         draft_width,
  input  logic signed [3:0]  slot_index,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_data,
  output logic               result_valid,
  output logic signed [16:0] token_out,
  output logic               has_token,
  output logic [1:0]         candidate_index,
  output logic [2:0]         chain_position,
  output logic               end_of_candidate,
  output logic               was_seen,
  output logic               last
);
  import smdt_pkg::*;

  localparam int AW = $clog2(VOCAB);
  localparam int RW = SLOTS * TOK_W;

  function automatic logic row_hit(logic [RW-1:0] r, logic signed [TOK_W-1:0] t);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (r[i*TOK_W +: TOK_W] == t) hit = 1'b1;
    end
    return hit;
  endfunction

  // Move t to slot 0; slots up to the first match or empty shift back by one.
  function automatic logic [RW-1:0] promote(logic [RW-1:0] r, logic signed [TOK_W-1:0] t);
    logic [RW-1:0] o;
    logic          stop;
    o    = r;
    stop = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i == 0) begin
        o[TOK_W-1:0] = t;
      end else if (!stop) begin
        o[i*TOK_W +: TOK_W] = r[(i-1)*TOK_W +: TOK_W];
      end
      if (r[i*TOK_W +: TOK_W] == t || r[i*TOK_W +: TOK_W] == TOK_EMPTY) stop = 1'b1;
    end
    return o;
  endfunction

  function automatic logic [7:0] bump(logic [7:0] s, logic seen);
    if (!seen) return 8'd0;
    if (s == STREAK_MAX) return s;
    return s + 8'd1;
  endfunction

  // Request registers
  logic [2:0]               req_q;
  logic signed [TOK_W-1:0]  tok_q;
  logic signed [TOK_W-1:0]  ids_q [4];
  logic [2:0]               cnt_q;
  logic [3:0]               depth_q;
  logic [2:0]               width_q;
  logic [3:0]               slot_q;

  // Working registers
  logic [7:0]               thr;
  logic [AW-1:0]            clr_addr;
  logic [AW-1:0]            cur;
  logic [RW-1:0]            row_q;
  logic [7:0]               streak_q;
  logic                     seen_q;
  logic [1:0]               k_q;
  logic [3:0]               pos_q;
  logic [2:0]               c_q;
  logic                     pend_valid;
  logic signed [TOK_W-1:0]  pend_tok;
  logic [1:0]               pend_ci;
  logic [2:0]               pend_pos;

  // Memory side
  logic [RW-1:0]            rd_row;
  logic [7:0]               rd_streak;
  logic [AW-1:0]            tok_addr;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic                     wr_en;
  logic [RW-1:0]            wr_row;
  logic [7:0]               wr_streak;

  // Request clamps
  logic [3:0]               depth_c;
  logic [2:0]               width_c;
  logic [2:0]               cnt_c;

  logic signed [TOK_W-1:0]  row0;
  logic signed [TOK_W-1:0]  start_c;
  logic signed [TOK_W-1:0]  read_val;
  logic                     obs_seen;
  logic                     push;
  logic signed [TOK_W-1:0]  push_tok;
  logic [2:0]               push_pos;

  logic                     emit;
  logic signed [TOK_W-1:0]  tok_out_next;
  logic                     has_next;
  logic [1:0]               ci_next;
  logic [2:0]               pos_next;
  logic                     eoc_next;
  logic                     seen_next;
  logic                     last_next;

  smdt_ram #(.WIDTH(RW), .DEPTH(VOCAB)) u_row_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_row),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  smdt_ram #(.WIDTH(8), .DEPTH(VOCAB)) u_streak_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_streak),
    .raddr (rd_addr),
    .rdata (rd_streak)
  );

  always_comb begin
    depth_c = draft_length;
    if (32'(depth_c) > MAX_DEPTH) depth_c = 4'(MAX_DEPTH);
    if (32'(depth_c) > DEPTH_CAP) depth_c = 4'(DEPTH_CAP);
    width_c = draft_width;
    if (32'(width_c) > SLOTS) width_c = 3'(SLOTS);
    if (32'(width_c) > WIDTH_CAP) width_c = 3'(WIDTH_CAP);
    cnt_c = id_count;
    if (32'(cnt_c) > TOPK_MAX) cnt_c = 3'(TOPK_MAX);
    if (32'(cnt_c) > COUNT_CAP) cnt_c = 3'(COUNT_CAP);
  end

  assign tok_addr = AW'(tok_q[15:0]);
  assign rd_addr  = cmd.rd_from_token ? tok_addr : cur;
  assign row0     = rd_row[TOK_W-1:0];
  assign obs_seen = row_hit(rd_row, ids_q[0]);

  always_comb begin
    start_c  = TOK_EMPTY;
    read_val = TOK_EMPTY;
    for (int i = 0; i < SLOTS; i++) begin
      if (32'(c_q) == i) start_c = row_q[i*TOK_W +: TOK_W];
      if (32'(slot_q[2:0]) == i) read_val = rd_row[i*TOK_W +: TOK_W];
    end
  end

  always_comb begin
    wr_en     = cmd.clear_wr || cmd.obs_write || cmd.topk_write;
    wr_addr   = cmd.clear_wr ? clr_addr : tok_addr;
    wr_row    = row_q;
    wr_streak = bump(streak_q, seen_q);
    if (cmd.clear_wr) begin
      wr_row    = {SLOTS{TOK_EMPTY}};
      wr_streak = 8'd0;
    end else if (cmd.obs_write) begin
      wr_row    = promote(rd_row, ids_q[0]);
      wr_streak = bump(rd_streak, obs_seen);
    end
  end

  always_comb begin
    sts.req        = req_q;
    sts.tok_ok     = tok_valid(tok_q, VOCAB);
    sts.id0_ok     = tok_valid(ids_q[0], VOCAB);
    sts.cnt_zero   = (cnt_q == 3'd0);
    sts.depth_zero = (depth_q == 4'd0);
    sts.slot_ok    = !slot_q[3] && (32'(slot_q[2:0]) < SLOTS);
    sts.lin_stop   = (rd_streak < thr) || row0[TOK_W-1];
    sts.chain_last = ((pos_q + 4'd1) == depth_q);
    sts.cand_more  = (c_q < width_q) && !start_c[TOK_W-1];
    sts.depth_one  = (depth_q == 4'd1);
    sts.cand_stop  = row0[TOK_W-1];
    sts.topk_done  = (k_q == 2'd0);
    sts.clear_done = (32'(clr_addr) == VOCAB - 1);
  end

  assign push     = cmd.lin_step || cmd.cand_first || cmd.cand_step;
  assign push_tok = cmd.cand_first ? start_c : row0;
  assign push_pos = cmd.cand_first ? 3'd0 : pos_q[2:0];

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THR_RESET;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cfg_valid) thr <= cfg_data;
      if (cmd.clear_wr) clr_addr <= clr_addr + AW'(1);
      if (cmd.latch_req) begin
        pend_valid <= 1'b0;
      end else if (push) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_q    <= req_type;
      tok_q    <= token;
      ids_q[0] <= id_first;
      ids_q[1] <= id_second;
      ids_q[2] <= id_third;
      ids_q[3] <= id_fourth;
      cnt_q    <= cnt_c;
      depth_q  <= depth_c;
      width_q  <= width_c;
      slot_q   <= slot_index;
      pos_q    <= 4'd0;
      c_q      <= 3'd0;
    end
    if (cmd.topk_load) begin
      row_q    <= rd_row;
      streak_q <= rd_streak;
      seen_q   <= sts.id0_ok && obs_seen;
      k_q      <= 2'(cnt_q - 3'd1);
    end
    if (cmd.cand_load) row_q <= rd_row;
    if (cmd.topk_step) begin
      // Lower ranks first so rank 0 lands in slot 0
      if (tok_valid(ids_q[k_q], VOCAB)) row_q <= promote(row_q, ids_q[k_q]);
      if (k_q != 2'd0) k_q <= k_q - 2'd1;
    end
    if (push) begin
      pend_tok <= push_tok;
      pend_ci  <= c_q[1:0];
      pend_pos <= push_pos;
      cur      <= AW'(push_tok[15:0]);
    end
    if (cmd.cand_first) begin
      pos_q <= 4'd1;
    end else if (cmd.lin_step || cmd.cand_step) begin
      pos_q <= pos_q + 4'd1;
    end
    if (cmd.cand_next) c_q <= c_q + 3'd1;
  end

  // Hold one token back so its end and last marks are known when it leaves
  always_comb begin
    emit         = 1'b0;
    tok_out_next = TOK_EMPTY;
    has_next     = 1'b0;
    ci_next      = 2'd0;
    pos_next     = 3'd0;
    eoc_next     = 1'b0;
    seen_next    = 1'b0;
    last_next    = 1'b1;
    priority if (cmd.obs_write || cmd.topk_write) begin
      emit      = 1'b1;
      seen_next = cmd.obs_write ? obs_seen : seen_q;
    end else if (cmd.read_emit) begin
      emit         = 1'b1;
      tok_out_next = read_val;
      has_next     = !read_val[TOK_W-1];
    end else if (push) begin
      emit         = pend_valid;
      tok_out_next = pend_tok;
      has_next     = 1'b1;
      ci_next      = pend_ci;
      pos_next     = pend_pos;
      eoc_next     = cmd.cand_first;
      last_next    = 1'b0;
    end else if (cmd.finish) begin
      emit = 1'b1;
      if (pend_valid) begin
        tok_out_next = pend_tok;
        has_next     = 1'b1;
        ci_next      = pend_ci;
        pos_next     = pend_pos;
        eoc_next     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      token_out        <= tok_out_next;
      has_token        <= has_next;
      candidate_index  <= ci_next;
      chain_position   <= pos_next;
      end_of_candidate <= eoc_next;
      was_seen         <= seen_next;
      last             <= last_next;
    end
  end

endmodule
